[hdl/swcw_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swcw_pkg
// Shared constants and the arctangent table of the swirl warp unit.
// ----------------------------------------------------------------------------
package swcw_pkg;

   // CORDIC datapath widths: Q30 vector with guard bits, angle in 2^-24 turn
   localparam int XW = 33;
   localparam int ZW = 25;
   localparam logic signed [XW-1:0] GAIN_Q30 = 33'sd652032874;

   // Field widths
   localparam int TURN_W = 19;
   localparam int OUT_W  = 18;
   localparam int QB     = 19;   // quotient bits of the turn division

   // Configuration port
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] REG_CENTER_X     = 4'd0;
   localparam logic [CSR_IDX_W-1:0] REG_CENTER_Y     = 4'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SWIRL_RADIUS = 4'd2;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_TURN     = 4'd3;

   // Quadrant codes (top two angle bits)
   localparam logic [1:0] QUAD_0 = 2'd0;
   localparam logic [1:0] QUAD_1 = 2'd1;
   localparam logic [1:0] QUAD_2 = 2'd2;
   localparam logic [1:0] QUAD_3 = 2'd3;

   // atan(2^-i) in units of 2^-24 turn
   function automatic logic [ZW-1:0] atan_val(input int idx);
      logic [ZW-1:0] val;
      begin
         case (idx)
            0:  val = 25'd2097152;
            1:  val = 25'd1238021;
            2:  val = 25'd654136;
            3:  val = 25'd332050;
            4:  val = 25'd166669;
            5:  val = 25'd83416;
            6:  val = 25'd41718;
            7:  val = 25'd20860;
            8:  val = 25'd10430;
            9:  val = 25'd5215;
            10: val = 25'd2608;
            11: val = 25'd1304;
            12: val = 25'd652;
            13: val = 25'd326;
            14: val = 25'd163;
            15: val = 25'd81;
            16: val = 25'd41;
            17: val = 25'd20;
            18: val = 25'd10;
            19: val = 25'd5;
            20: val = 25'd3;
            21: val = 25'd1;
            22: val = 25'd1;
            default: val = 25'd0;
         endcase
         return val;
      end
   endfunction

endpackage
`default_nettype wire

[hdl/swcw_sqrt_cell.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swcw_sqrt_cell
// One cell of the square root chain: settles one root bit per cell.
// ----------------------------------------------------------------------------
module swcw_sqrt_cell #(
   parameter int QW = 17,
   parameter int SW = 27
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              adv,
   input  wire logic              vld_in,
   input  wire logic [SW-1:0]     side_in,
   input  wire logic [2*QW-1:0]   v_in,
   input  wire logic [QW+2:0]     rem_in,
   input  wire logic [QW-1:0]     root_in,
   output logic                   vld_out,
   output logic [SW-1:0]          side_out,
   output logic [2*QW-1:0]        v_out,
   output logic [QW+2:0]          rem_out,
   output logic [QW-1:0]          root_out
);

   logic [QW+2:0] rem_sh;
   logic [QW+2:0] trial;
   logic          take;

   // bring down two radicand bits and try the next root bit
   always_comb begin
      rem_sh = {rem_in[QW:0], v_in[2*QW-1 -: 2]};
      trial  = {1'b0, root_in, 2'b01};
      take   = (rem_sh >= trial);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_out <= 1'b0;
      end else if (adv) begin
         vld_out <= vld_in;
      end
   end

   // advance data to the neighbor cell
   always_ff @(posedge clock) begin
      if (adv) begin
         side_out <= side_in;
         v_out    <= v_in << 2;
         rem_out  <= take ? (rem_sh - trial) : rem_sh;
         root_out <= {root_in[QW-2:0], take};
      end
   end

endmodule
`default_nettype wire

[hdl/swcw_div_cell.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swcw_div_cell
// One cell of the restoring divider chain: settles one quotient bit per cell.
// ----------------------------------------------------------------------------
module swcw_div_cell #(
   parameter int DW    = 36,
   parameter int RQW   = 16,
   parameter int SHIFT = 0,
   parameter int SW    = 28
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    adv,
   input  wire logic [RQW-1:0]          divisor,
   input  wire logic                    vld_in,
   input  wire logic [SW-1:0]           side_in,
   input  wire logic [DW-1:0]           rem_in,
   input  wire logic [swcw_pkg::QB-1:0] quo_in,
   output logic                         vld_out,
   output logic [SW-1:0]                side_out,
   output logic [DW-1:0]                rem_out,
   output logic [swcw_pkg::QB-1:0]      quo_out
);

   logic [DW-1:0] trial;
   logic          take;

   // compare against the divisor aligned to this quotient bit
   always_comb begin
      trial = DW'(divisor) << SHIFT;
      take  = (rem_in >= trial);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_out <= 1'b0;
      end else if (adv) begin
         vld_out <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         side_out <= side_in;
         rem_out  <= take ? (rem_in - trial) : rem_in;
         quo_out  <= {quo_in[swcw_pkg::QB-2:0], take};
      end
   end

endmodule
`default_nettype wire

[hdl/swcw_cordic_cell.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swcw_cordic_cell
// One micro-rotation of the rotation-mode CORDIC chain.
// ----------------------------------------------------------------------------
module swcw_cordic_cell #(
   parameter int IDX = 0,
   parameter int SW  = 29
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           adv,
   input  wire logic                           vld_in,
   input  wire logic [SW-1:0]                  side_in,
   input  wire logic signed [swcw_pkg::XW-1:0] x_in,
   input  wire logic signed [swcw_pkg::XW-1:0] y_in,
   input  wire logic signed [swcw_pkg::ZW-1:0] z_in,
   output logic                                vld_out,
   output logic [SW-1:0]                       side_out,
   output logic signed [swcw_pkg::XW-1:0]      x_out,
   output logic signed [swcw_pkg::XW-1:0]      y_out,
   output logic signed [swcw_pkg::ZW-1:0]      z_out
);

   localparam logic signed [swcw_pkg::ZW-1:0] ATAN = swcw_pkg::atan_val(IDX);

   logic signed [swcw_pkg::XW-1:0] xs;
   logic signed [swcw_pkg::XW-1:0] ys;

   always_comb begin
      xs = x_in >>> IDX;
      ys = y_in >>> IDX;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_out <= 1'b0;
      end else if (adv) begin
         vld_out <= vld_in;
      end
   end

   // turn toward the residual angle
   always_ff @(posedge clock) begin
      if (adv) begin
         side_out <= side_in;
         if (!z_in[swcw_pkg::ZW-1]) begin
            x_out <= x_in - ys;
            y_out <= y_in + xs;
            z_out <= z_in - ATAN;
         end else begin
            x_out <= x_in + ys;
            y_out <= y_in - xs;
            z_out <= z_in + ATAN;
         end
      end
   end

endmodule
`default_nettype wire

[hdl/swirl_coordinate_warp_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swirl_coordinate_warp_unit
// Swirl warp of a destination pixel coordinate about a configured centre.
// ----------------------------------------------------------------------------
// The square root, divider and CORDIC cell chains settle one bit or step per cell.
// Throughput: one transfer per cycle while req_stall is low; a one-entry skid stage backs the output.
// Reset clears all valid flags and loads the configuration registers with their reset values.
module swirl_coordinate_warp_unit #(
   parameter int COORD_BITS    = 12,
   parameter int FRAC_BITS     = 4,
   parameter int CORDIC_STAGES = 16
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire logic [COORD_BITS-1:0]                req_pixel_x,
   input  wire logic [COORD_BITS-1:0]                req_pixel_y,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic signed [swcw_pkg::OUT_W-1:0]         rsp_source_x,
   output logic signed [swcw_pkg::OUT_W-1:0]         rsp_source_y,
   output logic                                      rsp_inside_res,
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [swcw_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [swcw_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int CW   = COORD_BITS;
   localparam int F    = FRAC_BITS;
   localparam int NS   = CORDIC_STAGES;
   localparam int XW   = swcw_pkg::XW;
   localparam int ZW   = swcw_pkg::ZW;
   localparam int QB   = swcw_pkg::QB;
   localparam int OW   = swcw_pkg::OUT_W;
   localparam int TW   = swcw_pkg::TURN_W;
   localparam int DXW  = CW + 1;
   localparam int D2W  = 2 * CW + 1;
   localparam int QW   = CW + F + 1;
   localparam int RQW  = CW + F;
   localparam int PRW  = TW + RQW + 1;
   localparam int SW   = 2 * DXW + 1;
   localparam int SWD  = SW + 1;
   localparam int SWC  = SW + 2;
   localparam int PW   = DXW + XW;
   localparam int NW   = PW + 2;
   localparam int SH   = 30 - F;

   localparam logic signed [NW-1:0] ROUND_K = NW'(1) <<< (29 - F);
   localparam logic signed [NW-1:0] OUT_MAX = NW'((1 << (OW - 1)) - 1);
   localparam logic signed [NW-1:0] OUT_MIN = -(NW'(1) <<< (OW - 1));

   // ------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------
   logic [CW-1:0]        center_x_ff;
   logic [CW-1:0]        center_y_ff;
   logic [CW-1:0]        radius_ff;
   logic signed [TW-1:0] max_turn_ff;
   logic [2*CW-1:0]      rsq_ff;
   logic [RQW-1:0]       rq;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff <= '0;
         center_y_ff <= '0;
         radius_ff   <= CW'(1);
         max_turn_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            swcw_pkg::REG_CENTER_X:     center_x_ff <= csr_wdata[CW-1:0];
            swcw_pkg::REG_CENTER_Y:     center_y_ff <= csr_wdata[CW-1:0];
            swcw_pkg::REG_SWIRL_RADIUS: radius_ff   <= csr_wdata[CW-1:0];
            swcw_pkg::REG_MAX_TURN:     max_turn_ff <= csr_wdata[TW-1:0];
            default: ;
         endcase
      end
   end

   // register the squared radius; the fixed-point radius is derived combinationally
   always_ff @(posedge clock) begin
      rsq_ff <= radius_ff * radius_ff;
   end

   assign rq = RQW'(radius_ff) << F;

   // ------------------------------------------------------------------
   // Flow control: pipeline advances while the skid stage is empty
   // ------------------------------------------------------------------
   logic adv;
   logic skid_vld_ff;

   assign adv       = !skid_vld_ff;
   assign req_stall = skid_vld_ff;

   // ------------------------------------------------------------------
   // Offsets from the centre, squares, distance test
   // ------------------------------------------------------------------
   logic                  a_vld_ff, b_vld_ff, c_vld_ff;
   logic signed [DXW-1:0] a_dx_ff, a_dy_ff, b_dx_ff, b_dy_ff, c_dx_ff, c_dy_ff;
   logic [2*CW-1:0]       b_dx2_ff, b_dy2_ff;
   logic [D2W-1:0]        c_d2_ff;
   logic                  c_in_ff;
   logic [2*DXW-1:0]      sq_x, sq_y;
   logic [D2W-1:0]        d2_sum;

   always_comb begin
      sq_x   = a_dx_ff * a_dx_ff;
      sq_y   = a_dy_ff * a_dy_ff;
      d2_sum = D2W'(b_dx2_ff) + D2W'(b_dy2_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
         b_vld_ff <= 1'b0;
         c_vld_ff <= 1'b0;
      end else if (adv) begin
         a_vld_ff <= req_valid;
         b_vld_ff <= a_vld_ff;
         c_vld_ff <= b_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_dx_ff  <= $signed({1'b0, req_pixel_x}) - $signed({1'b0, center_x_ff});
         a_dy_ff  <= $signed({1'b0, req_pixel_y}) - $signed({1'b0, center_y_ff});
         b_dx_ff  <= a_dx_ff;
         b_dy_ff  <= a_dy_ff;
         b_dx2_ff <= sq_x[2*CW-1:0];
         b_dy2_ff <= sq_y[2*CW-1:0];
         c_dx_ff  <= b_dx_ff;
         c_dy_ff  <= b_dy_ff;
         c_d2_ff  <= d2_sum;
         c_in_ff  <= (d2_sum <= D2W'(rsq_ff));
      end
   end

   // ------------------------------------------------------------------
   // Square root chain
   // ------------------------------------------------------------------
   logic [2*QW-1:0] sq_v    [0:QW];
   logic [QW+2:0]   sq_rem  [0:QW];
   logic [QW-1:0]   sq_root [0:QW];
   logic            sq_vld  [0:QW];
   logic [SW-1:0]   sq_side [0:QW];

   assign sq_v[0]    = (2*QW)'(c_d2_ff) << (2 * F);
   assign sq_rem[0]  = '0;
   assign sq_root[0] = '0;
   assign sq_vld[0]  = c_vld_ff;
   assign sq_side[0] = {c_dx_ff, c_dy_ff, c_in_ff};

   for (genvar gi = 0; gi < QW; gi++) begin : g_sqrt
      swcw_sqrt_cell #(.QW(QW), .SW(SW)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .adv      (adv),
         .vld_in   (sq_vld[gi]),
         .side_in  (sq_side[gi]),
         .v_in     (sq_v[gi]),
         .rem_in   (sq_rem[gi]),
         .root_in  (sq_root[gi]),
         .vld_out  (sq_vld[gi+1]),
         .side_out (sq_side[gi+1]),
         .v_out    (sq_v[gi+1]),
         .rem_out  (sq_rem[gi+1]),
         .root_out (sq_root[gi+1])
      );
   end

   // ------------------------------------------------------------------
   // Clamp distance, turn numerator, sign and rounding bias
   // ------------------------------------------------------------------
   logic                  d_vld_ff, e_vld_ff, f_vld_ff;
   logic [SW-1:0]         d_side_ff, e_side_ff;
   logic [SWD-1:0]        f_side_ff;
   logic [RQW-1:0]        d_diff_ff;
   logic signed [PRW-1:0] e_num_ff;
   logic [PRW-1:0]        f_n_ff;
   logic [QW-1:0]         dq_cl;
   logic [QW-1:0]         diff_w;
   logic [PRW-1:0]        mag;

   always_comb begin
      dq_cl  = (sq_root[QW] > QW'(rq)) ? QW'(rq) : sq_root[QW];
      diff_w = QW'(rq) - dq_cl;
      mag    = e_num_ff[PRW-1] ? PRW'(-e_num_ff) : PRW'(e_num_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_vld_ff <= 1'b0;
         e_vld_ff <= 1'b0;
         f_vld_ff <= 1'b0;
      end else if (adv) begin
         d_vld_ff <= sq_vld[QW];
         e_vld_ff <= d_vld_ff;
         f_vld_ff <= e_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         d_side_ff <= sq_side[QW];
         d_diff_ff <= diff_w[RQW-1:0];
         e_side_ff <= d_side_ff;
         e_num_ff  <= max_turn_ff * $signed({1'b0, d_diff_ff});
         f_side_ff <= {e_side_ff, e_num_ff[PRW-1]};
         f_n_ff    <= mag + PRW'(rq >> 1);
      end
   end

   // ------------------------------------------------------------------
   // Divider chain: quotient of the numerator by the fixed-point radius
   // ------------------------------------------------------------------
   logic [PRW-1:0] dv_rem  [0:QB];
   logic [QB-1:0]  dv_quo  [0:QB];
   logic           dv_vld  [0:QB];
   logic [SWD-1:0] dv_side [0:QB];

   assign dv_rem[0]  = f_n_ff;
   assign dv_quo[0]  = '0;
   assign dv_vld[0]  = f_vld_ff;
   assign dv_side[0] = f_side_ff;

   for (genvar gi = 0; gi < QB; gi++) begin : g_div
      swcw_div_cell #(
         .DW    (PRW),
         .RQW   (RQW),
         .SHIFT (QB - 1 - gi),
         .SW    (SWD)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .adv      (adv),
         .divisor  (rq),
         .vld_in   (dv_vld[gi]),
         .side_in  (dv_side[gi]),
         .rem_in   (dv_rem[gi]),
         .quo_in   (dv_quo[gi]),
         .vld_out  (dv_vld[gi+1]),
         .side_out (dv_side[gi+1]),
         .rem_out  (dv_rem[gi+1]),
         .quo_out  (dv_quo[gi+1])
      );
   end

   // ------------------------------------------------------------------
   // Signed turn angle modulo one full turn
   // ------------------------------------------------------------------
   logic          g_vld_ff;
   logic [SW-1:0] g_side_ff;
   logic [15:0]   g_rot_ff;
   logic [QB-1:0] q_neg;
   logic [15:0]   rot_w;

   always_comb begin
      q_neg = -dv_quo[QB];
      if (radius_ff == '0) begin
         rot_w = '0;
      end else if (dv_side[QB][0]) begin
         rot_w = q_neg[15:0];
      end else begin
         rot_w = dv_quo[QB][15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         g_vld_ff <= 1'b0;
      end else if (adv) begin
         g_vld_ff <= dv_vld[QB];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         g_side_ff <= dv_side[QB][SWD-1:1];
         g_rot_ff  <= rot_w;
      end
   end

   // ------------------------------------------------------------------
   // CORDIC chain
   // ------------------------------------------------------------------
   logic signed [XW-1:0] cr_x    [0:NS];
   logic signed [XW-1:0] cr_y    [0:NS];
   logic signed [ZW-1:0] cr_z    [0:NS];
   logic                 cr_vld  [0:NS];
   logic [SWC-1:0]       cr_side [0:NS];

   assign cr_x[0]    = swcw_pkg::GAIN_Q30;
   assign cr_y[0]    = '0;
   assign cr_z[0]    = $signed(ZW'({g_rot_ff[13:0], 8'b0}));
   assign cr_vld[0]  = g_vld_ff;
   assign cr_side[0] = {g_side_ff, g_rot_ff[15:14]};

   for (genvar gi = 0; gi < NS; gi++) begin : g_cordic
      swcw_cordic_cell #(.IDX(gi), .SW(SWC)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .adv      (adv),
         .vld_in   (cr_vld[gi]),
         .side_in  (cr_side[gi]),
         .x_in     (cr_x[gi]),
         .y_in     (cr_y[gi]),
         .z_in     (cr_z[gi]),
         .vld_out  (cr_vld[gi+1]),
         .side_out (cr_side[gi+1]),
         .x_out    (cr_x[gi+1]),
         .y_out    (cr_y[gi+1]),
         .z_out    (cr_z[gi+1])
      );
   end

   // ------------------------------------------------------------------
   // Quadrant fold, products, rounding and saturation
   // ------------------------------------------------------------------
   logic                  h_vld_ff, i_vld_ff;
   logic [SW-1:0]         h_side_ff, i_side_ff;
   logic signed [XW-1:0]  h_c_ff, h_s_ff;
   logic signed [XW-1:0]  c_w, s_w;
   logic signed [PW-1:0]  i_xc_ff, i_ys_ff, i_xs_ff, i_yc_ff;
   logic signed [DXW-1:0] h_dx, h_dy, i_dx, i_dy;
   logic [1:0]            cr_quad;

   assign cr_quad = cr_side[NS][1:0];
   assign h_dx    = h_side_ff[SW-1 -: DXW];
   assign h_dy    = h_side_ff[DXW:1];
   assign i_dx    = i_side_ff[SW-1 -: DXW];
   assign i_dy    = i_side_ff[DXW:1];

   always_comb begin
      case (cr_quad)
         swcw_pkg::QUAD_0: begin
            c_w = cr_x[NS];
            s_w = cr_y[NS];
         end
         swcw_pkg::QUAD_1: begin
            c_w = -cr_y[NS];
            s_w = cr_x[NS];
         end
         swcw_pkg::QUAD_2: begin
            c_w = -cr_x[NS];
            s_w = -cr_y[NS];
         end
         swcw_pkg::QUAD_3: begin
            c_w = cr_y[NS];
            s_w = -cr_x[NS];
         end
         default: begin
            c_w = cr_x[NS];
            s_w = cr_y[NS];
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         h_vld_ff <= 1'b0;
         i_vld_ff <= 1'b0;
      end else if (adv) begin
         h_vld_ff <= cr_vld[NS];
         i_vld_ff <= h_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         h_side_ff <= cr_side[NS][SWC-1:2];
         h_c_ff    <= c_w;
         h_s_ff    <= s_w;
         i_side_ff <= h_side_ff;
         i_xc_ff   <= h_dx * h_c_ff;
         i_ys_ff   <= h_dy * h_s_ff;
         i_xs_ff   <= h_dx * h_s_ff;
         i_yc_ff   <= h_dy * h_c_ff;
      end
   end

   logic signed [NW-1:0] nx_w, ny_w, ox_w, oy_w, sx_w, sy_w;
   logic signed [OW-1:0] fin_x, fin_y;
   logic                 fin_in;

   // round the turned offset, restore the centre, pass outside points through, saturate
   always_comb begin
      fin_in = i_side_ff[0];
      nx_w = ((NW'(i_xc_ff) - NW'(i_ys_ff) + ROUND_K) >>> SH)
             + $signed(NW'(center_x_ff) << F);
      ny_w = ((NW'(i_xs_ff) + NW'(i_yc_ff) + ROUND_K) >>> SH)
             + $signed(NW'(center_y_ff) << F);
      ox_w = (NW'(i_dx) + $signed(NW'(center_x_ff))) <<< F;
      oy_w = (NW'(i_dy) + $signed(NW'(center_y_ff))) <<< F;
      sx_w = fin_in ? nx_w : ox_w;
      sy_w = fin_in ? ny_w : oy_w;
      if (sx_w > OUT_MAX) begin
         fin_x = OW'(OUT_MAX);
      end else if (sx_w < OUT_MIN) begin
         fin_x = OW'(OUT_MIN);
      end else begin
         fin_x = OW'(sx_w);
      end
      if (sy_w > OUT_MAX) begin
         fin_y = OW'(OUT_MAX);
      end else if (sy_w < OUT_MIN) begin
         fin_y = OW'(OUT_MIN);
      end else begin
         fin_y = OW'(sy_w);
      end
   end

   // ------------------------------------------------------------------
   // Output register with one-entry skid stage
   // ------------------------------------------------------------------
   logic                 rsp_vld_ff;
   logic signed [OW-1:0] rsp_x_ff, rsp_y_ff, skid_x_ff, skid_y_ff;
   logic                 rsp_in_ff, skid_in_ff;
   logic                 new_item;
   logic                 out_free;

   assign new_item = adv && i_vld_ff;
   assign out_free = !rsp_vld_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else if (out_free) begin
         rsp_vld_ff  <= skid_vld_ff || new_item;
         skid_vld_ff <= 1'b0;
      end else if (new_item) begin
         skid_vld_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         if (skid_vld_ff) begin
            rsp_x_ff  <= skid_x_ff;
            rsp_y_ff  <= skid_y_ff;
            rsp_in_ff <= skid_in_ff;
         end else begin
            rsp_x_ff  <= fin_x;
            rsp_y_ff  <= fin_y;
            rsp_in_ff <= fin_in;
         end
      end else if (new_item) begin
         skid_x_ff  <= fin_x;
         skid_y_ff  <= fin_y;
         skid_in_ff <= fin_in;
      end
   end

   assign rsp_valid      = rsp_vld_ff;
   assign rsp_source_x   = rsp_x_ff;
   assign rsp_source_y   = rsp_y_ff;
   assign rsp_inside_res = rsp_in_ff;

endmodule
`default_nettype wire

[hdl/swcw_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swcw_checker
// Port-level checks of the swirl warp unit, bound to the top level.
// ----------------------------------------------------------------------------
module swcw_checker (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              req_stall,
   input wire logic                              rsp_valid,
   input wire logic                              rsp_stall,
   input wire logic signed [swcw_pkg::OUT_W-1:0] rsp_source_x,
   input wire logic signed [swcw_pkg::OUT_W-1:0] rsp_source_y,
   input wire logic                              rsp_inside_res
);

   // nothing leaves the block right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result offered right after reset");

   // a stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_source_x)
         && $stable(rsp_source_y) && $stable(rsp_inside_res))
      else $error("stalled result changed");

   // input backpressure only follows a stalled result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(req_stall) |-> $past(rsp_valid && rsp_stall))
      else $error("input stalled without output backpressure");

   // points passed through keep a non-negative coordinate
   a_pass_sign: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_inside_res |-> !rsp_source_x[swcw_pkg::OUT_W-1]
         && !rsp_source_y[swcw_pkg::OUT_W-1])
      else $error("pass-through result negative");

endmodule

bind swirl_coordinate_warp_unit swcw_checker u_swcw_checker (
   .clock          (clock),
   .reset          (reset),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_source_x   (rsp_source_x),
   .rsp_source_y   (rsp_source_y),
   .rsp_inside_res (rsp_inside_res)
);
`default_nettype wire
